>>> src/pets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pets_pkg
// Request codes, result codes and the task table entry of the periodic
// event task scheduler.
// ----------------------------------------------------------------------------
package pets_pkg;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CHECK = 2'd2;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Event bit that requests reinitialization after reset.
	localparam logic [15:0] INIT_MASK_RESET = 16'h0001;

	// One task table entry as it is kept in memory.
	typedef struct packed {
		logic [31:0] due_time;
		logic [15:0] period;
		logic [15:0] trigger_mask;
	} entry_t;

endpackage

>>> src/periodic_event_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_task_scheduler
// Cooperative periodic task scheduler with a tick counter and a task table
// held in a synchronous memory.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-----------------------------------
// request   | start, accepted when !busy    | req_type, task_interval,
//           |                               | task_event_mask, pending_events
// result    | result_valid, one-cycle strobe| result_kind, task_index,
//           |                               | fired_by_event, table_full,
//           |                               | reinit_request, last
// config    | cfg_we, no wait               | cfg_wdata (init_event_mask)
//
// An add or a half-tick word is taken and busy stays low; the
// add response follows on the next cycle. A check holds busy while the
// table is walked, and an empty table gives only the closing result: the walk
// reads one table entry per cycle from the single memory read port, the
// entry is judged in the following cycle and written back if it fired on time, and
// the closing result follows the last entry.
// Reset is asynchronous and clears the tick counter, the task count and the
// control state; the table memory is not cleared, since only entries below
// the task count are ever read. The receiver cannot stall the result strobe.
//
module periodic_event_task_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] task_interval,
	input  logic [15:0] task_event_mask,
	input  logic [15:0] pending_events,
	// Result channel.
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [3:0]  task_index,
	output logic        fired_by_event,
	output logic        table_full,
	output logic        reinit_request,
	output logic        last,
	// Configuration register init_event_mask.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// The count must hold MAX_TASKS itself; a table index only has to reach
	// MAX_TASKS - 1.
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;

	// Control and scheduler state.
	logic [1:0]       state_q;
	logic [31:0]      tick_q;
	logic             half_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      init_mask_q;
	logic [15:0]      events_q;
	logic [CNT_W-1:0] rd_q;

	// Judge stage: the entry read in the previous cycle.
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	pets_pkg::entry_t rdata_s1;

	// Task table.
	pets_pkg::entry_t mem [MAX_TASKS];

	// Result register.
	logic             result_valid_q;
	logic [1:0]       result_kind_q;
	logic [3:0]       task_index_q;
	logic             fired_by_event_q;
	logic             table_full_q;
	logic             reinit_request_q;
	logic             last_q;

	logic             accept;
	logic             is_full;
	logic             rd_more;
	logic             due_hit;
	logic             ev_hit;
	logic             walk_done;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	pets_pkg::entry_t mem_wdata;
	logic [IDX_W+3:0] idx_ext;
	logic [IDX_W+3:0] slot_ext;

	logic             res_v;
	logic [1:0]       res_kind;
	logic [3:0]       res_idx;
	logic             res_ev;
	logic             res_full;
	logic             res_reinit;
	logic             res_last;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_full = (count_q >= CNT_W'(MAX_TASKS));
	assign rd_more = (rd_q < count_q);

	// On-time test is an unsigned compare; an event hit needs a shared bit.
	assign due_hit   = (tick_q >= rdata_s1.due_time);
	assign ev_hit    = (rdata_s1.trigger_mask != 16'd0) &&
	                   ((rdata_s1.trigger_mask & events_q) != 16'd0);
	assign walk_done = !rd_more && !v_s1;

	// Task indexes are reported modulo sixteen.
	assign idx_ext  = {4'd0, idx_s1};
	assign slot_ext = {4'd0, count_q[IDX_W-1:0]};

	// The single write port serves an add while idle and the due time
	// write-back during a walk; the two never meet. The walk writes entry
	// idx_s1 while it reads a later one, so no forwarding is needed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = rdata_s1;
		if (accept && (req_type == pets_pkg::REQ_ADD) && !is_full) begin
			mem_we                 = 1'b1;
			mem_wdata.due_time     = tick_q + {16'd0, task_interval};
			mem_wdata.period       = task_interval;
			mem_wdata.trigger_mask = task_event_mask;
		end else if ((state_q == ST_CHECK) && v_s1 && due_hit) begin
			mem_we             = 1'b1;
			mem_waddr          = idx_s1;
			mem_wdata.due_time = rdata_s1.due_time + {16'd0, rdata_s1.period};
		end
	end

	// Next result word, at most one source per cycle.
	always_comb begin
		res_v      = 1'b0;
		res_kind   = pets_pkg::KIND_ADD;
		res_idx    = 4'd0;
		res_ev     = 1'b0;
		res_full   = 1'b0;
		res_reinit = 1'b0;
		res_last   = 1'b0;
		if (accept && (req_type == pets_pkg::REQ_ADD)) begin
			res_v    = 1'b1;
			res_full = is_full;
			res_idx  = is_full ? 4'd0 : slot_ext[3:0];
			res_last = 1'b1;
		end else if (state_q == ST_CHECK) begin
			if (v_s1 && (due_hit || ev_hit)) begin
				res_v    = 1'b1;
				res_kind = pets_pkg::KIND_FIRED;
				res_idx  = idx_ext[3:0];
				res_ev   = !due_hit;
			end else if (walk_done) begin
				res_v      = 1'b1;
				res_kind   = pets_pkg::KIND_DONE;
				res_reinit = ((events_q & init_mask_q) != 16'd0);
				res_last   = 1'b1;
			end
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if ((state_q == ST_CHECK) && rd_more) begin
			rdata_s1 <= mem[rd_q[IDX_W-1:0]];
			idx_s1   <= rd_q[IDX_W-1:0];
		end
	end

	// Result payload needs no reset.
	always_ff @(posedge clk) begin
		result_kind_q    <= res_kind;
		task_index_q     <= res_idx;
		fired_by_event_q <= res_ev;
		table_full_q     <= res_full;
		reinit_request_q <= res_reinit;
		last_q           <= res_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tick_q         <= 32'd0;
			half_q         <= 1'b0;
			count_q        <= '0;
			init_mask_q    <= pets_pkg::INIT_MASK_RESET;
			events_q       <= 16'd0;
			rd_q           <= '0;
			v_s1           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res_v;
			if (cfg_we) begin
				init_mask_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							pets_pkg::REQ_ADD: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							pets_pkg::REQ_TICK: begin
								// Two half-ticks make one tick.
								half_q <= !half_q;
								if (half_q) begin
									tick_q <= tick_q + 32'd1;
								end
							end
							pets_pkg::REQ_CHECK: begin
								state_q  <= ST_CHECK;
								events_q <= pending_events;
								rd_q     <= '0;
								v_s1     <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					v_s1 <= rd_more;
					if (rd_more) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign result_kind    = result_kind_q;
	assign task_index     = task_index_q;
	assign fired_by_event = fired_by_event_q;
	assign table_full     = table_full_q;
	assign reinit_request = reinit_request_q;
	assign last           = last_q;

`ifndef ASSERT_OFF
	// The task count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count exceeds table size");

	// Every accepted add answers on the next cycle.
	a_add_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == pets_pkg::REQ_ADD) |=>
		result_valid && (result_kind == pets_pkg::KIND_ADD) && last)
		else $error("add response missing");

	// A check makes the block busy on the next cycle.
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == pets_pkg::REQ_CHECK) |=> busy)
		else $error("check did not start a walk");

	// The closing result leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == pets_pkg::KIND_DONE) |-> !busy && last)
		else $error("closing result while still walking");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic event task scheduler. A driver feeds
// request words from a queue, a predictor keeps its own tick counter and task
// table and works out every result word, and a monitor compares the result
// strobes field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int TASK_SLOTS = 16;
	// The fourth request code has no meaning; the block must ignore it.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// One request word as it sits on the request ports.
	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] interval;
		logic [15:0] evmask;
		logic [15:0] events;
	} req_word_t;

	// One result word as the block presents it on its result strobe.
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] idx;
		logic       by_event;
		logic       full;
		logic       reinit;
		logic       last;
	} result_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = pets_pkg::REQ_TICK;
	logic [15:0] task_interval = '0;
	logic [15:0] task_event_mask = '0;
	logic [15:0] pending_events = '0;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [3:0]  task_index;
	logic        fired_by_event;
	logic        table_full;
	logic        reinit_request;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	periodic_event_task_scheduler #(
		.MAX_TASKS(TASK_SLOTS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.task_interval  (task_interval),
		.task_event_mask(task_event_mask),
		.pending_events (pending_events),
		.result_valid   (result_valid),
		.result_kind    (result_kind),
		.task_index     (task_index),
		.fired_by_event (fired_by_event),
		.table_full     (table_full),
		.reinit_request (reinit_request),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Words waiting to be driven, the word currently on the ports, and the
	// result words that the scheduler still owes us, oldest first.
	req_word_t    word_queue[$];
	req_word_t    on_port;
	result_word_t awaited_results[$];
	int           words_queued = 0;
	int           words_taken = 0;
	int           send_idle_pct = 0;
	int           errors = 0;

	// Our own copy of the scheduler state. Table entries at or above
	// tasks_held are never read, so they need no reset value.
	logic [31:0]  tick_now = '0;
	logic         half_toggle = 1'b0;
	int           tasks_held = 0;
	logic [31:0]  due_tbl[TASK_SLOTS];
	logic [15:0]  period_tbl[TASK_SLOTS];
	logic [15:0]  trig_tbl[TASK_SLOTS];
	logic [15:0]  init_mask = pets_pkg::INIT_MASK_RESET;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Advance the scheduler state by one accepted request word and queue the
	// result words it must produce.
	task automatic sched_step(input req_word_t w);
		result_word_t r;
		int i;
		r = '0;
		case (w.req)
			pets_pkg::REQ_ADD: begin
				r.kind = pets_pkg::KIND_ADD;
				r.last = 1'b1;
				if (tasks_held >= TASK_SLOTS) begin
					// A full table refuses the task and reports slot zero.
					r.full = 1'b1;
				end else begin
					due_tbl[tasks_held] = tick_now + 32'(w.interval);
					period_tbl[tasks_held] = w.interval;
					trig_tbl[tasks_held] = w.evmask;
					r.idx = 4'(tasks_held);
					tasks_held++;
				end
				awaited_results.push_back(r);
			end
			pets_pkg::REQ_TICK: begin
				// Two half-ticks make one tick.
				if (half_toggle) begin
					half_toggle = 1'b0;
					tick_now = tick_now + 32'd1;
				end else begin
					half_toggle = 1'b1;
				end
			end
			pets_pkg::REQ_CHECK: begin
				for (i = 0; i < tasks_held; i++) begin
					r = '0;
					r.kind = pets_pkg::KIND_FIRED;
					r.idx = 4'(i);
					if (tick_now >= due_tbl[i]) begin
						// On time wins over an event; the due time moves on by one
						// period and wraps at 32 bits.
						due_tbl[i] = due_tbl[i] + 32'(period_tbl[i]);
						awaited_results.push_back(r);
					end else if (trig_tbl[i] != '0 && (w.events & trig_tbl[i]) != '0) begin
						r.by_event = 1'b1;
						awaited_results.push_back(r);
					end
				end
				r = '0;
				r.kind = pets_pkg::KIND_DONE;
				r.last = 1'b1;
				r.reinit = (w.events & init_mask) != '0;
				awaited_results.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	// Driver. A word is taken at an edge where start is high and busy is low;
	// the next word is put up in the same step so start never drops between
	// back-to-back words unless the sender chooses to idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				sched_step(on_port);
				words_taken++;
			end
			if (!start || !busy) begin
				if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_port = word_queue.pop_front();
					start <= 1'b1;
					req_type <= on_port.req;
					task_interval <= on_port.interval;
					task_event_mask <= on_port.evmask;
					pending_events <= on_port.events;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every strobe is a result word that must match the oldest one
	// still owed; the receiver has no way to hold it off.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_valid) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result word with none awaited, kind", int'(result_kind), -1);
			end else begin
				want = awaited_results.pop_front();
				if (result_kind != want.kind)
					report_mismatch("result_kind", int'(result_kind), int'(want.kind));
				if (task_index != want.idx)
					report_mismatch("task_index", int'(task_index), int'(want.idx));
				if (fired_by_event != want.by_event)
					report_mismatch("fired_by_event", int'(fired_by_event),
						int'(want.by_event));
				if (table_full != want.full)
					report_mismatch("table_full", int'(table_full), int'(want.full));
				if (reinit_request != want.reinit)
					report_mismatch("reinit_request", int'(reinit_request),
						int'(want.reinit));
				if (last != want.last)
					report_mismatch("last", int'(last), int'(want.last));
			end
		end
	end

	task automatic send(input logic [1:0] req, input logic [15:0] interval,
			input logic [15:0] evmask, input logic [15:0] events);
		req_word_t w;
		w.req = req;
		w.interval = interval;
		w.evmask = evmask;
		w.events = events;
		word_queue.push_back(w);
		words_queued++;
	endtask

	// Event masks are mostly empty or a single bit, so that event firing is
	// selective, with a share of fully random patterns.
	function automatic logic [15:0] some_mask();
		int pick;
		pick = $urandom_range(9);
		if (pick < 3)
			return '0;
		else if (pick < 7)
			return 16'h0001 << $urandom_range(15);
		else
			return 16'($urandom);
	endfunction

	// Random traffic. Ticks and checks dominate so that short-period tasks
	// come due again and again; adds keep coming after the table has filled
	// so that refusals are exercised. Ignored words do not count.
	task automatic random_words(input int count);
		int n;
		int pick;
		logic [15:0] iv;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			iv = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(6));
			if (pick < 3) begin
				send(REQ_UNUSED, iv, some_mask(), some_mask());
			end else begin
				if (pick < 18)
					send(pets_pkg::REQ_ADD, iv, some_mask(), some_mask());
				else if (pick < 60)
					send(pets_pkg::REQ_TICK, iv, some_mask(), some_mask());
				else
					send(pets_pkg::REQ_CHECK, iv, some_mask(), some_mask());
				n++;
			end
		end
	endtask

	// Hold the sender off until every word is taken and every result word has
	// come, then allow a check of a full table to run out in case the last
	// word was one that produces nothing.
	task automatic settle();
		while (words_taken != words_queued || awaited_results.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_init_mask(input logic [15:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		init_mask = value;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening with the reset value of the init event mask.
		send_idle_pct = 15;
		// Checks of an empty table: only the closing word, with and without
		// the init event.
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h0001);
		send(pets_pkg::REQ_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFE);
		// A zero-period task is due at every check; the others cover the
		// extreme period, the top and bottom event bits and an all-ones mask.
		send(pets_pkg::REQ_ADD, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 16'h0000);
		send(pets_pkg::REQ_ADD, 16'h0001, 16'h8000, 16'h0000);
		send(pets_pkg::REQ_ADD, 16'h0002, 16'h0001, 16'h0000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h8000);
		send(pets_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h0001);
		send(pets_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h0000);
		send(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(pets_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'hFFFF);
		send(pets_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h0002);
		random_words(170);

		// Every init event bit set, with a sluggish sender.
		set_init_mask(16'hFFFF);
		send_idle_pct = 85;
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h8000);
		random_words(170);

		// No init event at all, with no idling.
		set_init_mask(16'h0000);
		send_idle_pct = 0;
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'hFFFF);
		random_words(100);

		// Only the top event bit requests reinitialization.
		set_init_mask(16'h8000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h8000);
		send(pets_pkg::REQ_CHECK, 16'h0000, 16'h0000, 16'h7FFF);
		random_words(60);

		settle();
		if (awaited_results.size() != 0)
			report_mismatch("result words never delivered", 0, awaited_results.size());
		if (errors == 0) begin
			$display("periodic_event_task_scheduler verification clean");
		end else begin
			$display("periodic_event_task_scheduler verification failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("periodic_event_task_scheduler verification failed");
		$finish;
	end

endmodule

>>> files.f
src/pets_pkg.sv
src/periodic_event_task_scheduler.sv
test/tb.sv
